// File: rtl/core/lhbs_pkg.sv
// ----------------------------------------------------------------------------
// lhbs_pkg
// Shared types and constants of the 3x3 high-boost sharpening block.
// ----------------------------------------------------------------------------
`default_nettype none

package lhbs_pkg;

	localparam int PIX_W         = 8;
	localparam int CFG_W         = 11;
	localparam int BOOST_W       = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int MIN_DIM       = 3;

	// gain = 64 + boost_q4, i.e. (4 + alpha) in sixteenths
	localparam int BOOST_BIAS = 64;
	localparam int ROUND_HALF = 8;
	localparam int PIX_MAX    = 255;

	localparam logic [CFG_W-1:0]   WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0]   HEIGHT_RST = CFG_W'(480);
	localparam logic [BOOST_W-1:0] BOOST_RST  = BOOST_W'(16);

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;

	localparam cfg_idx_t REG_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_HEIGHT = 2'd1;
	localparam cfg_idx_t REG_BOOST  = 2'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic             command;
		logic [PIX_W-1:0] pixel;
	} in_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             frame_last;
	} out_beat_t;

	// one line store entry: the two rows above the incoming pixel
	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
	} line_pair_t;

	// item leaving the front end
	typedef struct packed {
		logic             valid;
		logic             drain;
		logic             emit;
		logic             interior;
		logic             last;
		logic [PIX_W-1:0] px;
	} s1_t;

endpackage

`default_nettype wire

// File: rtl/core/lhbs_line_mem.sv
// ----------------------------------------------------------------------------
// lhbs_line_mem
// Line store: one entry per column holding the upper and middle rows.
// ----------------------------------------------------------------------------
`default_nettype none

module lhbs_line_mem #(
	parameter int MAX_WIDTH = lhbs_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output lhbs_pkg::line_pair_t              rd_data,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  lhbs_pkg::line_pair_t              wr_data
);
	import lhbs_pkg::*;

	line_pair_t mem_q [MAX_WIDTH];
	line_pair_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// File: rtl/core/lhbs_ctrl.sv
// ----------------------------------------------------------------------------
// lhbs_ctrl
// Config registers, raster counters, drain tracking and the line store read.
// ----------------------------------------------------------------------------
`default_nettype none

module lhbs_ctrl #(
	parameter int MAX_WIDTH = lhbs_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  lhbs_pkg::cfg_idx_t                cfg_index,
	input  lhbs_pkg::cfg_data_t               cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  lhbs_pkg::in_beat_t                in_data,
	input  wire logic                         s1_take,
	output lhbs_pkg::s1_t                     s1,
	output logic [$clog2(MAX_WIDTH)-1:0]      col_s1,
	output logic [lhbs_pkg::BOOST_W-1:0]      boost,
	output logic                              rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr
);
	import lhbs_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CMP_W = (COL_W > CFG_W) ? COL_W : CFG_W;
	localparam int WMAX  = (MAX_WIDTH > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : MAX_WIDTH;

	logic [CFG_W-1:0]   width_q, height_q;
	logic [BOOST_W-1:0] boost_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               tail_q;
	logic [CFG_W-1:0]   drain_q;
	s1_t                s1_q;
	logic [COL_W-1:0]   col_s1_q;

	logic [CFG_W-1:0] w_eff, h_eff;
	logic accept, is_pix, take_pix, take_drain;
	logic col_last, row_last, drain_last, emit, interior, restart;

	always_comb begin
		if (width_q < CFG_W'(MIN_DIM)) begin
			w_eff = CFG_W'(MIN_DIM);
		end else if (width_q > CFG_W'(WMAX)) begin
			w_eff = CFG_W'(WMAX);
		end else begin
			w_eff = width_q;
		end
		if (height_q < CFG_W'(MIN_DIM)) begin
			h_eff = CFG_W'(MIN_DIM);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign in_stall   = s1_q.valid && !s1_take;
	assign accept     = in_valid && !in_stall;
	assign is_pix     = (in_data.command == CMD_PIXEL);
	assign take_pix   = accept && is_pix && !tail_q;
	assign take_drain = accept && !is_pix && tail_q;

	assign col_last   = (CMP_W'(col_q) == CMP_W'(w_eff) - CMP_W'(1));
	assign row_last   = (CFG_W'(row_q) == h_eff - CFG_W'(1));
	assign drain_last = (drain_q == w_eff);
	assign emit       = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
	assign interior   = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	assign restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT) ||
		(cfg_index == REG_BOOST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			boost_q  <= BOOST_RST;
			col_q    <= '0;
			row_q    <= '0;
			tail_q   <= 1'b0;
			drain_q  <= '0;
			s1_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_BOOST:  boost_q  <= cfg_data[BOOST_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				tail_q <= 1'b0;
			end else if (take_pix) begin
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						row_q   <= '0;
						tail_q  <= 1'b1;
						drain_q <= '0;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else if (take_drain) begin
				if (drain_last) begin
					col_q  <= '0;
					row_q  <= '0;
					tail_q <= 1'b0;
				end else begin
					drain_q <= drain_q + CFG_W'(1);
				end
			end

			// tail pixels and early drains are taken but leave nothing behind
			if (accept) begin
				s1_q.valid    <= take_pix || take_drain;
				s1_q.drain    <= take_drain;
				s1_q.emit     <= emit;
				s1_q.interior <= interior;
				s1_q.last     <= take_drain && drain_last;
				s1_q.px       <= in_data.pixel;
			end else if (s1_take) begin
				s1_q.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1_q <= col_q;
		end
	end

	assign s1      = s1_q;
	assign col_s1  = col_s1_q;
	assign boost   = boost_q;
	assign rd_en   = take_pix;
	assign rd_addr = col_q;

endmodule

`default_nettype wire

// File: rtl/core/lhbs_kernel.sv
// ----------------------------------------------------------------------------
// lhbs_kernel
// 3x3 window, boost multiply, round/clamp and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lhbs_kernel (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  lhbs_pkg::s1_t                s1,
	input  lhbs_pkg::line_pair_t         rd_data,
	input  wire logic [lhbs_pkg::BOOST_W-1:0] boost,
	output logic                         s1_take,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output lhbs_pkg::out_beat_t          out_data
);
	import lhbs_pkg::*;

	localparam int GAIN_W = BOOST_W + 1;
	localparam int PROD_W = GAIN_W + PIX_W;
	localparam int NSUM_W = PIX_W + 2;
	localparam int DIFF_W = PROD_W + 1;

	typedef struct packed {
		logic valid;
		logic interior;
		logic last;
	} stg_t;

	logic [PIX_W-1:0] win_q [3][3];
	stg_t             s2_q, s3_q;
	logic [PROD_W-1:0] prod_s3;
	logic [NSUM_W-1:0] nsum_s3;
	logic              out_valid_q;
	out_beat_t         out_data_q;

	logic en2, en3;
	logic [GAIN_W-1:0] gain;
	logic signed [DIFF_W-1:0] s_diff, s_rnd;
	logic [DIFF_W-5:0] v_rnd;
	logic [PIX_W-1:0]  res;

	assign en3     = !out_valid_q || !out_stall;
	assign en2     = !s3_q.valid || en3;
	assign s1_take = !s2_q.valid || en2;

	assign gain = GAIN_W'(BOOST_BIAS) + GAIN_W'(boost);

	always_comb begin
		s_diff = $signed({1'b0, prod_s3}) - $signed({(DIFF_W - NSUM_W - 4)'(0), nsum_s3, 4'b0});
		s_rnd  = s_diff + DIFF_W'(ROUND_HALF);
		v_rnd  = s_rnd[DIFF_W-1:4];
		if (!s3_q.interior || s_diff < 0) begin
			res = '0;
		end else if (v_rnd > (DIFF_W-4)'(PIX_MAX)) begin
			res = PIX_W'(PIX_MAX);
		end else begin
			res = v_rnd[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_q        <= '0;
			s3_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				s2_q.valid    <= s1.valid && (s1.drain || s1.emit);
				s2_q.interior <= s1.interior && !s1.drain;
				s2_q.last     <= s1.last;
			end
			if (en2) begin
				s3_q <= s2_q;
			end
			if (en3) begin
				out_valid_q <= s3_q.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		// window moves once per pixel beat, in raster order
		if (s1_take && s1.valid && !s1.drain) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_data.upper;
			win_q[1][2] <= rd_data.middle;
			win_q[2][2] <= s1.px;
		end
		if (en2) begin
			prod_s3 <= PROD_W'(gain) * PROD_W'(win_q[1][1]);
			nsum_s3 <= NSUM_W'(win_q[0][1]) + NSUM_W'(win_q[2][1]) +
				NSUM_W'(win_q[1][0]) + NSUM_W'(win_q[1][2]);
		end
		if (en3) begin
			out_data_q.out_pixel  <= res;
			out_data_q.frame_last <= s3_q.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/core/laplacian_high_boost_sharpen.sv
// An accepted pixel or drain beat passes the line store read, window shift, boost
//   multiply and round/clamp into the output reg on its way to its result beat.
// Throughput: one beat per clock while out_stall is low; the line store has one read
//   and one write port; a column is written back when its front-end beat is taken.
// Reset: config returns to 640x480, alpha one; counters and valids clear.
//   Line stores are not cleared and the block takes input right after reset.
// ----------------------------------------------------------------------------
// laplacian_high_boost_sharpen
// 3x3 high-boost sharpening of an 8-bit raster stream with drain tail.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_high_boost_sharpen #(
	parameter int MAX_WIDTH = lhbs_pkg::MAX_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  lhbs_pkg::cfg_idx_t  cfg_index,
	input  lhbs_pkg::cfg_data_t cfg_data,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  lhbs_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output lhbs_pkg::out_beat_t out_data
);
	import lhbs_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	s1_t                s1;
	logic [COL_W-1:0]   col_s1, rd_addr;
	logic [BOOST_W-1:0] boost;
	logic               rd_en, wr_en, s1_take;
	line_pair_t         rd_data, wr_data;

	lhbs_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.s1_take   (s1_take),
		.s1        (s1),
		.col_s1    (col_s1),
		.boost     (boost),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	// rows shift down by one: middle moves to upper, new pixel becomes middle.
	// Consecutive pixels hit different columns, so no read/write overlap.
	assign wr_en   = s1_take && s1.valid && !s1.drain;
	assign wr_data = '{upper: rd_data.middle, middle: s1.px};

	lhbs_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	lhbs_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.rd_data   (rd_data),
		.boost     (boost),
		.s1_take   (s1_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: rtl/core/lhbs_checker.sv
// ----------------------------------------------------------------------------
// lhbs_checker
// Port-level checks of the sharpening block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lhbs_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_stall,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input lhbs_pkg::out_beat_t out_data
);
	import lhbs_pkg::*;

	// held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// the frame's last result is a border pixel
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_last |-> out_data.out_pixel == '0)
		else $error("frame_last beat carries nonzero pixel");

	// with an empty output register the pipeline must be moving
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

endmodule

bind laplacian_high_boost_sharpen lhbs_checker u_lhbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/tb_laplacian_high_boost_sharpen.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laplacian_high_boost_sharpen
// Self-checking bench for the 3x3 high-boost sharpener. A scoreboard class
// mirrors the line stores, window and frame counters, predicts every result
// beat from the accepted input beats and compares them in order. Directed
// frames cover the border, clamp, tail and restart cases. Random phases follow:
// small frames under varied sizes and gains, plus a tall frame broken off early
// and a wide frame that wraps at the widest row.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------

module tb_laplacian_high_boost_sharpen;

	import lhbs_pkg::*;

	localparam int LATENCY = 4;
	localparam int RANDOM_BEATS = 280;
	localparam cfg_idx_t REG_SPARE = 2'd3;

	class sharpen_scoreboard;
		logic [PIX_W-1:0] upper_row [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] middle_row [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] win [3][3];
		int unsigned col_in;
		int unsigned row_in;
		int unsigned out_pos;
		bit draining;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [BOOST_W-1:0] boost_reg;
		out_beat_t sharpened_q [$];
		int errors;
		int taken;

		function new();
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			boost_reg = BOOST_RST;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (win[r, c])
				win[r][c] = '0;
			restart();
			errors = 0;
			taken = 0;
		endfunction

		function void restart();
			col_in = 0;
			row_in = 0;
			out_pos = 0;
			draining = 1'b0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < MIN_DIM)
				return MIN_DIM;
			if (width_reg > MAX_WIDTH_DEF)
				return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg < MIN_DIM)
				return MIN_DIM;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return height_reg;
		endfunction

		function int unsigned frame_size();
			return eff_width() * eff_height();
		endfunction

		function void configure(cfg_idx_t idx, cfg_data_t val);
			case (idx)
				REG_WIDTH: width_reg = val;
				REG_HEIGHT: height_reg = val;
				REG_BOOST: boost_reg = val[BOOST_W-1:0];
				default: return;
			endcase
			restart();
		endfunction

		// (64 + q) * c - 16 * (N + S + W + E) in sixteenths, round half up, clamp
		function logic [PIX_W-1:0] high_boost();
			int centre;
			int around;
			int acc;
			centre = win[1][1];
			around = win[0][1] + win[2][1] + win[1][0] + win[1][2];
			acc = (BOOST_BIAS + boost_reg) * centre - 16 * around;
			if (acc < 0)
				return '0;
			acc = (acc + ROUND_HALF) >>> 4;
			if (acc > PIX_MAX)
				acc = PIX_MAX;
			return acc[PIX_W-1:0];
		endfunction

		function void take_beat(in_beat_t beat);
			int unsigned w;
			logic [PIX_W-1:0] above;
			logic [PIX_W-1:0] mid;
			out_beat_t res;
			bit emit;
			w = eff_width();
			res.out_pixel = '0;
			res.frame_last = 1'b0;
			if (beat.command == CMD_PIXEL) begin
				if (draining || col_in >= w)
					return;
				above = upper_row[col_in];
				mid = middle_row[col_in];
				upper_row[col_in] = mid;
				middle_row[col_in] = beat.pixel;
				for (int r = 0; r < 3; r++) begin
					win[r][0] = win[r][1];
					win[r][1] = win[r][2];
				end
				win[0][2] = above;
				win[1][2] = mid;
				win[2][2] = beat.pixel;
				emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
				if (row_in >= 2 && col_in >= 2)
					res.out_pixel = high_boost();
				col_in++;
				if (col_in >= w) begin
					col_in = 0;
					row_in++;
					if (row_in >= eff_height()) begin
						row_in = 0;
						draining = 1'b1;
					end
				end
				taken++;
				if (emit) begin
					sharpened_q.push_back(res);
					out_pos++;
				end
				return;
			end
			// drain beat: only counts once the whole frame is in
			if (!draining)
				return;
			taken++;
			if (out_pos + 1 >= frame_size()) begin
				res.frame_last = 1'b1;
				restart();
			end else begin
				out_pos++;
			end
			sharpened_q.push_back(res);
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_beat(out_beat_t got);
			out_beat_t want;
			if (sharpened_q.size() == 0) begin
				report($sformatf("result beat with nothing pending: pixel %0d last %0b",
					got.out_pixel, got.frame_last));
				return;
			end
			want = sharpened_q.pop_front();
			if (got.out_pixel !== want.out_pixel)
				report($sformatf("out_pixel %0d, predicted %0d", got.out_pixel,
					want.out_pixel));
			if (got.frame_last !== want.frame_last)
				report($sformatf("frame_last %0b, predicted %0b", got.frame_last,
					want.frame_last));
		endtask

		function int pending();
			return sharpened_q.size();
		endfunction

		function bit in_tail();
			return draining;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_WIDTH;
	cfg_data_t cfg_data = '0;
	logic in_valid = 1'b0;
	in_beat_t in_data = '0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;

	bit quiet = 1'b0;
	int gap_pct = 15;
	int stall_pct = 10;
	int stall_left = 0;
	sharpen_scoreboard sb = new();

	laplacian_high_boost_sharpen i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: stalls in random bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(out_data);
	end

	task automatic send_beat(logic cmd, logic [PIX_W-1:0] px);
		in_beat_t beat;
		beat.command = cmd;
		beat.pixel = px;
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		sb.take_beat(beat);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.configure(idx, val);
		cfg_we <= 1'b0;
	endtask

	task automatic pause_for_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// all results in, plus pipeline time for beats that produce none
	task automatic settle();
		pause_for_results();
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(int style, int base);
		int v;
		case (style)
			0: return PIX_W'($urandom_range(0, PIX_MAX));
			1: begin
				v = base + $urandom_range(0, 16) - 8;
				if (v < 0)
					v = 0;
				if (v > PIX_MAX)
					v = PIX_MAX;
				return v[PIX_W-1:0];
			end
			default: return $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
		endcase
	endfunction

	// stop_at = 0: whole frame and its drain tail; otherwise break off early
	task automatic run_frame(int unsigned stop_at);
		int unsigned npx;
		int style;
		int base;
		npx = (stop_at != 0) ? stop_at : sb.frame_size();
		style = $urandom_range(0, 2);
		base = $urandom_range(0, PIX_MAX);
		for (int unsigned i = 0; i < npx; i++) begin
			if ($urandom_range(0, 39) == 0)
				send_beat(CMD_DRAIN, PIX_W'($urandom));
			if ($urandom_range(0, 299) == 0)
				pause_for_results();
			send_beat(CMD_PIXEL, pick_pixel(style, base));
		end
		if (stop_at == 0)
			while (sb.in_tail()) begin
				if ($urandom_range(0, 19) == 0)
					send_beat(CMD_PIXEL, PIX_W'($urandom));
				send_beat(CMD_DRAIN, PIX_W'($urandom));
			end
	endtask

	initial begin
		int unsigned target;
		int n_frames;
		bit wrote;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: early drain is dropped, first-row pixels give nothing
		send_beat(CMD_DRAIN, 8'h00);
		send_beat(CMD_PIXEL, 8'hFF);
		send_beat(CMD_PIXEL, 8'h00);
		settle();

		// under-range sizes clamp to 3x3; spare index changes nothing
		write_reg(REG_WIDTH, 11'd0);
		write_reg(REG_HEIGHT, 11'd2);
		write_reg(REG_BOOST, 11'd255);
		write_reg(REG_SPARE, 11'd5);

		// bright centre on black: saturates at full gain
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_PIXEL, 8'd255);
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_DRAIN, 8'd255);
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_PIXEL, 8'd0);
		send_beat(CMD_PIXEL, 8'd0);
		pause_for_results();
		// pixel during the tail is dropped
		send_beat(CMD_PIXEL, 8'd77);
		while (sb.in_tail())
			send_beat(CMD_DRAIN, 8'd0);
		// partial frame, then a register write restarts
		send_beat(CMD_PIXEL, 8'd200);
		send_beat(CMD_PIXEL, 8'd13);
		send_beat(CMD_PIXEL, 8'd255);
		send_beat(CMD_PIXEL, 8'd1);
		settle();

		// height over range, narrowest row; broken off after a few rows
		write_reg(REG_WIDTH, 11'd1);
		write_reg(REG_HEIGHT, 11'd2047);
		write_reg(REG_BOOST, 11'd16);
		run_frame(12);
		settle();

		// widest row: wrap at 1024 columns, broken off in the second row
		write_reg(REG_WIDTH, 11'd1024);
		write_reg(REG_HEIGHT, 11'd0);
		run_frame(MAX_WIDTH_DEF + 6);

		target = sb.taken + RANDOM_BEATS;
		while (sb.taken < target) begin
			settle();
			quiet = (sb.taken + 200 >= target);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 35;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 8;
				default: stall_pct = 25;
			endcase
			wrote = 1'b0;
			if ($urandom_range(0, 1)) begin
				write_reg(REG_WIDTH, cfg_data_t'(($urandom_range(0, 5) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 10)));
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_HEIGHT, cfg_data_t'(($urandom_range(0, 5) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 6)));
				wrote = 1'b1;
			end
			if (!wrote || $urandom_range(0, 1))
				case ($urandom_range(0, 3))
					0: write_reg(REG_BOOST, 11'd0);
					1: write_reg(REG_BOOST, 11'd255);
					2: write_reg(REG_BOOST, 11'd16);
					default: write_reg(REG_BOOST, cfg_data_t'($urandom_range(0, 255)));
				endcase
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_SPARE, cfg_data_t'($urandom_range(0, 2047)));
			n_frames = $urandom_range(1, 3);
			for (int f = 0; f < n_frames; f++)
				if (f == n_frames - 1 && $urandom_range(0, 4) == 0)
					run_frame($urandom_range(1, sb.frame_size() - 1));
				else
					run_frame(0);
		end

		quiet = 1'b1;
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
